// File: rtl/bir_pkg.sv
// Shared constants, types and the axis mapping function of the bilinear resampler.
`default_nettype none
package bir_pkg;
	localparam int MAX_WIDTH    = 128;
	localparam int MAX_HEIGHT   = 128;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_TARGET   = 1024;

	localparam int X_W     = $clog2(MAX_WIDTH);
	localparam int Y_W     = $clog2(MAX_HEIGHT);
	localparam int C_W     = $clog2(MAX_CHANNELS);
	localparam int COORD_W = (X_W > Y_W) ? X_W : Y_W;
	localparam int D_W     = $clog2(MAX_TARGET);
	localparam int SCALE_W = 23;
	localparam int T_W     = D_W + 1 + SCALE_W;
	localparam int IP_W    = T_W - 17;
	localparam int BANK_AW = (Y_W - 1) + (X_W - 1) + C_W;
	localparam int BANK_DEPTH = 2 ** BANK_AW;

	localparam logic       REQ_STORE = 1'b0;
	localparam logic       REQ_READ  = 1'b1;
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_CHANNELS   = 3'd2,
		REG_TARGET     = 3'd3,
		REG_SCALE_X    = 3'd4,
		REG_SCALE_Y    = 3'd5,
		REG_READY      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic         req_type;
		logic [6:0]   src_x;
		logic [6:0]   src_y;
		logic [9:0]   dst_x;
		logic [9:0]   dst_y;
		logic [1:0]   channel;
		logic [7:0]   sample;
	} req_t;

	typedef struct packed {
		logic [15:0]  value_q8;
		logic [1:0]   status;
	} res_t;

	typedef struct packed {
		logic [7:0]          src_width;
		logic [7:0]          src_height;
		logic [2:0]          channel_count;
		logic [10:0]         grid_side;
		logic [SCALE_W-1:0]  scale_x_q16;
		logic [SCALE_W-1:0]  scale_y_q16;
		logic                image_ready;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic [15:0]        w;
	} axis_t;

	// t is (2d+1)*scale in Q.17; n is the saturated axis length.
	function automatic axis_t map_axis(input logic [T_W-1:0] t, input logic [7:0] n);
		axis_t a;
		logic [T_W-1:0]  u;
		logic [IP_W-1:0] ip;
		logic [7:0]      nm1;
		nm1 = n - 8'd1;
		u   = t - T_W'(65536);
		ip  = u[T_W-1:17];
		a   = '0;
		if (t < T_W'(65536)) begin
			a.lo = '0;
			a.hi = (n > 8'd1) ? COORD_W'(1) : '0;
		end else if (ip >= IP_W'(nm1)) begin
			a.lo = COORD_W'(nm1);
			a.hi = COORD_W'(nm1);
		end else begin
			a.lo = COORD_W'(ip);
			a.hi = COORD_W'(ip + IP_W'(1));
			a.w  = u[16:1];
		end
		return a;
	endfunction
endpackage
`default_nettype wire

// File: rtl/bilinear_image_resampler_core.sv
// Top level of the bilinear image resampler: request pipeline and banked source store.
//
//  channel   signals                               direction  handshake
//  request   start, busy, req                      in         start && !busy
//  result    done, result                          out        done, one cycle
//  config    psel penable pwrite paddr pwdata ...  in/out     APB, pready high
//
// One request enters every cycle; busy is never raised. A read request passes
// through stages s1 to s5 to its result; a store request gives none. The
// rate is set by the four source banks split by column and row parity, which
// serve all four neighbours in the same read. Reset clears control and
// configuration; the source store itself is not cleared. Results cannot stall.
`default_nettype none
module bilinear_image_resampler_core import bir_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	output logic             done,
	output res_t             result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	cfg_t cfg;

	req_t           req_s1;
	logic           valid_s1;
	logic [1:0]     status_c;
	logic [7:0]     wsat, hsat;
	logic [2:0]     ncsat;
	logic [T_W-1:0] tx_s2, ty_s2;
	req_t           req_s2;
	logic           valid_s2;
	logic [1:0]     status_s2;
	axis_t          axx, axy;
	logic [BANK_AW-1:0] waddr;
	logic [BANK_AW-1:0] raddr [4];
	logic [7:0]         rdata [4];
	logic               wok;
	logic               rvalid_s3;
	logic [1:0]         status_s3;
	logic               x0p_s3, x1p_s3, y0p_s3, y1p_s3;
	logic [15:0]        wx_s3, wy_s3;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	bir_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	assign wsat  = (cfg.src_width  > 8'(MAX_WIDTH))  ? 8'(MAX_WIDTH)  : cfg.src_width;
	assign hsat  = (cfg.src_height > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : cfg.src_height;
	assign ncsat = (cfg.channel_count > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS)
	                                                      : cfg.channel_count;

	always_comb begin
		priority if (!cfg.image_ready || wsat == 8'd0 || hsat == 8'd0) begin
			status_c = ST_EMPTY;
		end else if (11'(req_s1.dst_x) >= cfg.grid_side
		          || 11'(req_s1.dst_y) >= cfg.grid_side
		          || 3'(req_s1.channel) >= ncsat) begin
			status_c = ST_RANGE;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			rvalid_s3 <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			rvalid_s3 <= valid_s2 && (req_s2.req_type == REQ_READ);
		end
	end

	always_ff @(posedge clk) begin
		req_s1    <= req;
		req_s2    <= req_s1;
		status_s2 <= status_c;
		tx_s2 <= T_W'({req_s1.dst_x, 1'b1}) * T_W'(cfg.scale_x_q16);
		ty_s2 <= T_W'({req_s1.dst_y, 1'b1}) * T_W'(cfg.scale_y_q16);
		status_s3 <= status_s2;
		x0p_s3 <= axx.lo[0];
		x1p_s3 <= axx.hi[0];
		y0p_s3 <= axy.lo[0];
		y1p_s3 <= axy.hi[0];
		wx_s3  <= axx.w;
		wy_s3  <= axy.w;
	end

	assign axx = map_axis(tx_s2, wsat);
	assign axy = map_axis(ty_s2, hsat);

	// Stores and reads issue in the same stage, so a read sees every earlier store.
	assign waddr = {req_s2.src_y[Y_W-1:1], req_s2.src_x[X_W-1:1], req_s2.channel[C_W-1:0]};
	assign wok   = valid_s2 && (req_s2.req_type == REQ_STORE)
	            && (32'(req_s2.src_x) < 32'(MAX_WIDTH))
	            && (32'(req_s2.src_y) < 32'(MAX_HEIGHT))
	            && (32'(req_s2.channel) < 32'(MAX_CHANNELS));

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [COORD_W-1:0] xs, ys;
		logic               we_b;
		assign xs = (axx.lo[0] == b[0]) ? axx.lo : axx.hi;
		assign ys = (axy.lo[0] == b[1]) ? axy.lo : axy.hi;
		assign raddr[b] = {ys[Y_W-1:1], xs[X_W-1:1], req_s2.channel[C_W-1:0]};
		assign we_b = wok && (req_s2.src_x[0] == b[0]) && (req_s2.src_y[0] == b[1]);

		bir_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
			.clk   (clk),
			.we    (we_b),
			.waddr (waddr),
			.wdata (req_s2.sample),
			.raddr (raddr[b]),
			.rdata (rdata[b])
		);
	end

	bir_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (rvalid_s3),
		.status (status_s3),
		.p00    (rdata[{y0p_s3, x0p_s3}]),
		.p10    (rdata[{y0p_s3, x1p_s3}]),
		.p01    (rdata[{y1p_s3, x0p_s3}]),
		.p11    (rdata[{y1p_s3, x1p_s3}]),
		.wx     (wx_s3),
		.wy     (wy_s3),
		.done   (done),
		.result (result)
	);
endmodule
`default_nettype wire

// File: rtl/bir_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module bir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/bir_cfg.sv
// Register file behind the APB-style configuration port.
`default_nettype none
module bir_cfg import bir_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output cfg_t             cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[4:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width     <= 8'd0;
			cfg_q.src_height    <= 8'd0;
			cfg_q.channel_count <= 3'd3;
			cfg_q.grid_side     <= 11'd224;
			cfg_q.scale_x_q16   <= SCALE_W'(65536);
			cfg_q.scale_y_q16   <= SCALE_W'(65536);
			cfg_q.image_ready   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_SRC_WIDTH:  cfg_q.src_width     <= pwdata[7:0];
				REG_SRC_HEIGHT: cfg_q.src_height    <= pwdata[7:0];
				REG_CHANNELS:   cfg_q.channel_count <= pwdata[2:0];
				REG_TARGET:     cfg_q.grid_side     <= pwdata[10:0];
				REG_SCALE_X:    cfg_q.scale_x_q16   <= pwdata[SCALE_W-1:0];
				REG_SCALE_Y:    cfg_q.scale_y_q16   <= pwdata[SCALE_W-1:0];
				REG_READY:      cfg_q.image_ready   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SRC_WIDTH:  prdata = {24'd0, cfg_q.src_width};
			REG_SRC_HEIGHT: prdata = {24'd0, cfg_q.src_height};
			REG_CHANNELS:   prdata = {29'd0, cfg_q.channel_count};
			REG_TARGET:     prdata = {21'd0, cfg_q.grid_side};
			REG_SCALE_X:    prdata = 32'(cfg_q.scale_x_q16);
			REG_SCALE_Y:    prdata = 32'(cfg_q.scale_y_q16);
			REG_READY:      prdata = {31'd0, cfg_q.image_ready};
			default:        prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/bir_blend.sv
// Two-stage bilinear blend of the four neighbour samples with rounding to Q8.8.
`default_nettype none
module bir_blend import bir_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	input  wire logic [1:0]  status,
	input  wire logic [7:0]  p00,
	input  wire logic [7:0]  p10,
	input  wire logic [7:0]  p01,
	input  wire logic [7:0]  p11,
	input  wire logic [15:0] wx,
	input  wire logic [15:0] wy,
	output logic             done,
	output res_t             result
);
	logic [16:0] ax, bx, ay, by;
	logic [23:0] top_s4, bot_s4;
	logic [16:0] ay_s4, by_s4;
	logic [1:0]  status_s4;
	logic        valid_s4;
	logic [40:0] acc;
	res_t        result_s5;
	logic        valid_s5;

	assign ax  = 17'd65536 - 17'(wx);
	assign bx  = 17'(wx);
	assign ay  = 17'd65536 - 17'(wy);
	assign by  = 17'(wy);
	assign acc = 41'(top_s4) * 41'(ay_s4) + 41'(bot_s4) * 41'(by_s4) + 41'd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		top_s4    <= 24'(25'(p00) * 25'(ax) + 25'(p10) * 25'(bx));
		bot_s4    <= 24'(25'(p01) * 25'(ax) + 25'(p11) * 25'(bx));
		ay_s4     <= ay;
		by_s4     <= by;
		status_s4 <= status;
		result_s5.status   <= status_s4;
		result_s5.value_q8 <= (status_s4 == ST_OK) ? acc[39:24] : 16'd0;
	end

	assign done   = valid_s5;
	assign result = result_s5;
endmodule
`default_nettype wire
